/* src/dcc_pkg.sv */
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types, constants and the byte-wide crc32 step for the datagram checker.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int unsigned MAX_DATAGRAM_DEF = 2048;
    localparam int unsigned HDR_BYTES        = 16;
    localparam int unsigned CRC_FIELD_START  = 12;
    localparam int unsigned LEN_W            = 12;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_RESET = 32'h5453_4554;

    typedef enum logic [2:0] {
        VRD_PASS      = 3'd0,
        VRD_MAGIC_ERR = 3'd1,
        VRD_LEN_ERR   = 3'd2,
        VRD_CRC_ERR   = 3'd3,
        VRD_RUNT      = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]      test_id;
        verdict_t         verdict;
        logic [LEN_W-1:0] received_length;
        logic [31:0]      calc_crc;
    } out_beat_t;

    // registered input beat handed to the datagram stage
    typedef struct packed {
        logic     valid;
        in_beat_t beat;
    } dcc_stage_t;

    // reflected crc32, eight bit steps unrolled
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

/* src/dcc_input_stage.sv */
// ----------------------------------------------------------------------------
// dcc_input_stage
// Input register for byte beats, refilled in the cycle it drains.
// ----------------------------------------------------------------------------
module dcc_input_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  dcc_pkg::in_beat_t byte_beat,
    output dcc_pkg::dcc_stage_t stage,
    input  logic              take
);
    import dcc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign byte_ready = !valid_reg || take;
    assign valid_next = byte_ready ? byte_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            beat_reg <= byte_beat;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.beat  = beat_reg;

endmodule

/* src/dcc_datagram.sv */
// ----------------------------------------------------------------------------
// dcc_datagram
// Header capture, crc update, verdict and the result register.
// ----------------------------------------------------------------------------
module dcc_datagram #(
    parameter int unsigned MAX_DATAGRAM = dcc_pkg::MAX_DATAGRAM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dcc_pkg::dcc_stage_t stage,
    output logic                take,
    input  logic                magic_we,
    input  logic [31:0]         magic_wdata,
    output logic                result_valid,
    input  logic                result_ready,
    output dcc_pkg::out_beat_t  result_beat
);
    import dcc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DATAGRAM + 1);

    logic [31:0]   magic_reg;
    logic [CW-1:0] count_reg, count_next, count_upd;
    logic [31:0]   crc_reg, crc_next, crc_upd;
    logic [31:0]   hmagic_reg, hmagic_next, hmagic_upd;
    logic [31:0]   htid_reg, htid_next, htid_upd;
    logic [31:0]   hlen_reg, hlen_next, hlen_upd;
    logic [31:0]   hcrc_reg, hcrc_next, hcrc_upd;
    logic          result_valid_reg, result_valid_next;
    out_beat_t     result_reg, result_next;
    logic          active;
    logic [31:0]   shifted;
    logic [31:0]   final_crc;
    logic [31:0]   body_len;
    verdict_t      verdict;

    assign take = stage.valid &&
                  (!stage.beat.last_byte || !result_valid_reg || result_ready);

    // bytes past the buffer size leave the count, crc and header fields alone
    assign active  = count_reg < CW'(MAX_DATAGRAM);
    assign shifted = 32'(stage.beat.data_byte) << {count_reg[1:0], 3'b000};

    always_comb
    begin
        count_upd  = count_reg;
        crc_upd    = crc_reg;
        hmagic_upd = hmagic_reg;
        htid_upd   = htid_reg;
        hlen_upd   = hlen_reg;
        hcrc_upd   = hcrc_reg;
        if (active)
        begin
            if (count_reg < CW'(HDR_BYTES))
            begin
                case (count_reg[3:2])
                    2'd0:    hmagic_upd = hmagic_reg | shifted;
                    2'd1:    htid_upd   = htid_reg | shifted;
                    2'd2:    hlen_upd   = hlen_reg | shifted;
                    default: hcrc_upd   = hcrc_reg | shifted;
                endcase
            end
            // crc field itself is skipped
            if (count_reg < CW'(CRC_FIELD_START) || count_reg >= CW'(HDR_BYTES))
            begin
                crc_upd = crc32_byte(crc_reg, stage.beat.data_byte);
            end
            count_upd = count_reg + CW'(1);
        end
    end

    assign final_crc = ~crc_upd;
    assign body_len  = 32'(count_upd) - 32'(HDR_BYTES);

    always_comb
    begin
        if (count_upd < CW'(HDR_BYTES))
        begin
            verdict = VRD_RUNT;
        end
        else if (hmagic_upd != magic_reg)
        begin
            verdict = VRD_MAGIC_ERR;
        end
        else if (hlen_upd != body_len)
        begin
            verdict = VRD_LEN_ERR;
        end
        else if (hcrc_upd != final_crc)
        begin
            verdict = VRD_CRC_ERR;
        end
        else
        begin
            verdict = VRD_PASS;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        hmagic_next = hmagic_reg;
        htid_next   = htid_reg;
        hlen_next   = hlen_reg;
        hcrc_next   = hcrc_reg;
        result_next = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (take)
        begin
            if (stage.beat.last_byte)
            begin
                // verdict beat, then start fresh
                count_next  = '0;
                crc_next    = CRC_SEED;
                hmagic_next = '0;
                htid_next   = '0;
                hlen_next   = '0;
                hcrc_next   = '0;
                result_valid_next = 1'b1;
                result_next.verdict         = verdict;
                result_next.received_length = LEN_W'(count_upd);
                if (verdict == VRD_RUNT)
                begin
                    result_next.test_id  = '0;
                    result_next.calc_crc = '0;
                end
                else
                begin
                    result_next.test_id  = htid_upd;
                    result_next.calc_crc = final_crc;
                end
            end
            else
            begin
                count_next  = count_upd;
                crc_next    = crc_upd;
                hmagic_next = hmagic_upd;
                htid_next   = htid_upd;
                hlen_next   = hlen_upd;
                hcrc_next   = hcrc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg        <= MAGIC_RESET;
            count_reg        <= '0;
            crc_reg          <= CRC_SEED;
            hmagic_reg       <= '0;
            htid_reg         <= '0;
            hlen_reg         <= '0;
            hcrc_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (magic_we)
            begin
                magic_reg <= magic_wdata;
            end
            count_reg        <= count_next;
            crc_reg          <= crc_next;
            hmagic_reg       <= hmagic_next;
            htid_reg         <= htid_next;
            hlen_reg         <= hlen_next;
            hcrc_reg         <= hcrc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_beat  = result_reg;

endmodule

/* src/datagram_crc32_checker_core.sv */
// ----------------------------------------------------------------------------
// datagram_crc32_checker_core
// Byte-stream test datagram checker with reflected crc32 and header checks.
// ----------------------------------------------------------------------------
// Takes one byte beat per clock through an input register and a single
// datagram stage whose eight-bit unrolled crc step and header compare are
// combinational; that stage sets the rate. A verdict beat is written to the
// result register as its last byte leaves the input register, and byte beats
// keep flowing while a verdict waits unless a second verdict would overrun it.
// magic_we writes the expected magic word at once and is meant for idle time.
module datagram_crc32_checker_core #(
    parameter int unsigned MAX_DATAGRAM = dcc_pkg::MAX_DATAGRAM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  dcc_pkg::in_beat_t  byte_beat,
    output logic               result_valid,
    input  logic               result_ready,
    output dcc_pkg::out_beat_t result_beat,
    input  logic               magic_we,
    input  logic [31:0]        magic_wdata
);
    import dcc_pkg::*;

    dcc_stage_t stage;
    logic       take;

    dcc_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_beat  (byte_beat),
        .stage      (stage),
        .take       (take)
    );

    dcc_datagram #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_datagram (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .take         (take),
        .magic_we     (magic_we),
        .magic_wdata  (magic_wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

`ifndef ASSERT_OFF
    a_short_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.verdict == VRD_RUNT |->
        result_beat.test_id == 32'd0 && result_beat.calc_crc == 32'd0)
        else $error("too short verdict with nonzero id or crc");

    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.verdict == VRD_RUNT |->
        result_beat.received_length < LEN_W'(HDR_BYTES))
        else $error("too short verdict on a full header");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage.valid |-> byte_ready)
        else $error("input stage empty but not ready");

    a_nonlast_drains: assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid && !stage.beat.last_byte |-> take)
        else $error("non-last beat stalled in datagram stage");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the datagram crc32 checker: a byte driver and a
// verdict monitor around a cycle-free datagram predictor, run over several
// expected-magic settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    import dcc_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_DG         = MAX_DATAGRAM_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_BYTES    = 170;
    localparam int NUM_PHASES     = 8;

    typedef enum int {
        DG_GOOD,
        DG_WRONG_MAGIC,
        DG_BAD_LEN,
        DG_BAD_CRC,
        DG_SHORT,
        DG_NOISE
    } dg_kind_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    in_beat_t    byte_beat    = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_beat_t   result_beat;
    logic        magic_we     = 1'b0;
    logic [31:0] magic_wdata  = '0;

    // datagram predictor state
    logic [31:0] cfg_magic   = MAGIC_RESET;
    int unsigned dg_count    = 0;
    logic [31:0] dg_crc      = CRC_SEED;
    logic [31:0] hdr_magic   = '0;
    logic [31:0] hdr_test_id = '0;
    logic [31:0] hdr_length  = '0;
    logic [31:0] hdr_crc     = '0;

    out_beat_t expected_verdicts[$];
    in_beat_t  pending_bytes[$];

    int   fail_count       = 0;
    int   bytes_taken      = 0;
    int   verdicts_checked = 0;
    int   magic_settings   = 0;
    int   verdict_tally[5] = '{default: 0};
    int   send_idle_pct    = 0;
    int   recv_stall_pct   = 0;
    int   hold_req         = 0;
    int   hold_seen        = 0;
    int   hold_left        = 0;
    int   quiet_cycles     = 0;
    logic in_fire          = 1'b0;

    datagram_crc32_checker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_beat    (byte_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat),
        .magic_we     (magic_we),
        .magic_wdata  (magic_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // bit-serial reflected crc, lsb first
    function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic in_beat_t beat_of(input logic [7:0] d, input logic l);
        in_beat_t b;
        b.data_byte = d;
        b.last_byte = l;
        return b;
    endfunction

    task automatic clear_datagram();
        dg_count    = 0;
        dg_crc      = CRC_SEED;
        hdr_magic   = '0;
        hdr_test_id = '0;
        hdr_length  = '0;
        hdr_crc     = '0;
    endtask

    // absorb one accepted byte, queue a verdict on the last one
    task automatic track_byte(input in_beat_t b);
        int unsigned pos;
        out_beat_t   res;
        if (dg_count < MAX_DG)
        begin
            pos = dg_count;
            if (pos < HDR_BYTES)
            begin
                case (pos / 4)
                    0: hdr_magic[8 * (pos % 4) +: 8]   = b.data_byte;
                    1: hdr_test_id[8 * (pos % 4) +: 8] = b.data_byte;
                    2: hdr_length[8 * (pos % 4) +: 8]  = b.data_byte;
                    default: hdr_crc[8 * (pos % 4) +: 8] = b.data_byte;
                endcase
            end
            if (pos < CRC_FIELD_START || pos >= HDR_BYTES)
                dg_crc = crc32_next(dg_crc, b.data_byte);
            dg_count = pos + 1;
        end
        if (b.last_byte)
        begin
            res.test_id         = '0;
            res.verdict         = VRD_RUNT;
            res.received_length = LEN_W'(dg_count);
            res.calc_crc        = '0;
            if (dg_count >= HDR_BYTES)
            begin
                res.test_id  = hdr_test_id;
                res.calc_crc = ~dg_crc;
                if (hdr_magic != cfg_magic)
                    res.verdict = VRD_MAGIC_ERR;
                else if (hdr_length != 32'(dg_count - HDR_BYTES))
                    res.verdict = VRD_LEN_ERR;
                else if (hdr_crc != ~dg_crc)
                    res.verdict = VRD_CRC_ERR;
                else
                    res.verdict = VRD_PASS;
            end
            expected_verdicts.push_back(res);
            verdict_tally[res.verdict]++;
            clear_datagram();
        end
    endtask

    // build one datagram of the given kind and queue its bytes
    task automatic queue_datagram(input dg_kind_t kind, input int plen, output int n);
        logic [7:0]  dg[];
        logic [31:0] magic;
        logic [31:0] declared;
        logic [31:0] crc;
        int          total;
        int          covered;
        if (kind == DG_SHORT || kind == DG_NOISE)
        begin
            total = (kind == DG_SHORT) ? $urandom_range(1, HDR_BYTES - 1) : $urandom_range(1, 48);
            dg = new[total];
            foreach (dg[i])
                dg[i] = 8'($urandom);
        end
        else
        begin
            total   = HDR_BYTES + plen;
            covered = (total < MAX_DG) ? total : MAX_DG;
            dg = new[total];
            foreach (dg[i])
                dg[i] = 8'($urandom);
            magic = cfg_magic;
            if (kind == DG_WRONG_MAGIC)
                magic = magic ^ (32'h1 << $urandom_range(0, 31));
            // bytes past the buffer size do not count toward the length
            declared = 32'(covered - HDR_BYTES);
            if (kind == DG_BAD_LEN)
                declared = $urandom_range(0, 1) ? declared + $urandom_range(1, 3)
                                                : declared ^ ($urandom | 32'h1);
            for (int k = 0; k < 4; k++)
            begin
                dg[k]     = magic[8 * k +: 8];
                dg[8 + k] = declared[8 * k +: 8];
            end
            crc = CRC_SEED;
            for (int i = 0; i < covered; i++)
            begin
                if (i < CRC_FIELD_START || i >= HDR_BYTES)
                    crc = crc32_next(crc, dg[i]);
            end
            crc = ~crc;
            if (kind == DG_BAD_CRC)
                crc = crc ^ (32'h1 << $urandom_range(0, 31));
            for (int k = 0; k < 4; k++)
                dg[12 + k] = crc[8 * k +: 8];
        end
        foreach (dg[i])
            pending_bytes.push_back(beat_of(dg[i], i == total - 1));
        n = total;
    endtask

    task automatic queue_random_traffic(input int budget);
        int       queued;
        int       roll;
        int       plen;
        int       n;
        dg_kind_t kind;
        queued = 0;
        while (queued < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                kind = DG_GOOD;
            else if (roll < 50)
                kind = DG_WRONG_MAGIC;
            else if (roll < 60)
                kind = DG_BAD_LEN;
            else if (roll < 70)
                kind = DG_BAD_CRC;
            else if (roll < 85)
                kind = DG_SHORT;
            else
                kind = DG_NOISE;
            plen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 96) : $urandom_range(0, 16);
            queue_datagram(kind, plen, n);
            queued += n;
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 75;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 75;
            end
            default:
            begin
                send_idle_pct  = 31;
                recv_stall_pct = 31;
            end
        endcase
    endtask

    // sender holds off until every verdict is back, then lets the pipe drain
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || byte_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_magic(input logic [31:0] v);
        @(negedge clk);
        magic_we    <= 1'b1;
        magic_wdata <= v;
        cfg_magic    = v;
        magic_settings++;
        @(negedge clk);
        magic_we    <= 1'b0;
    endtask

    // byte driver
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || in_fire))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                byte_beat  <= pending_bytes.pop_front();
                byte_valid <= 1'b1;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // verdict receiver with random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_seen != hold_req)
        begin
            hold_seen     = hold_req;
            hold_left     = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on each byte beat, check each verdict beat
    always @(posedge clk)
    begin
        out_beat_t want;
        in_fire <= rst_n && byte_valid && byte_ready;
        if (rst_n && byte_valid && byte_ready)
        begin
            track_byte(byte_beat);
            bytes_taken++;
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("verdict beat with nothing pending: test_id %h verdict %0d",
                       result_beat.test_id, result_beat.verdict);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                verdicts_checked++;
                if (result_beat.test_id !== want.test_id)
                begin
                    $error("test_id mismatch: expected %h actual %h",
                           want.test_id, result_beat.test_id);
                    fail_count++;
                end
                if (result_beat.verdict !== want.verdict)
                begin
                    $error("verdict mismatch: expected %0d actual %0d",
                           want.verdict, result_beat.verdict);
                    fail_count++;
                end
                if (result_beat.received_length !== want.received_length)
                begin
                    $error("received_length mismatch: expected %0d actual %0d",
                           want.received_length, result_beat.received_length);
                    fail_count++;
                end
                if (result_beat.calc_crc !== want.calc_crc)
                begin
                    $error("calc_crc mismatch: expected %h actual %h",
                           want.calc_crc, result_beat.calc_crc);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic at all
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && byte_ready) || (result_valid && result_ready) || magic_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0] magic_plan[NUM_PHASES];
        int          n;
        magic_plan = '{MAGIC_RESET, 32'h0000_0000, 32'hFFFF_FFFF, $urandom,
                       MAGIC_RESET ^ 32'h1, $urandom, 32'h0000_0000, 32'hFFFF_FFFF};
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: single-byte datagrams at both byte extremes, minimal good header
        pending_bytes.push_back(beat_of(8'h00, 1'b1));
        pending_bytes.push_back(beat_of(8'hFF, 1'b1));
        queue_datagram(DG_GOOD, 0, n);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_magic(magic_plan[p]);
            if (p == 4)
            begin
                // receiver holds off while one-byte datagrams back up the input
                set_idling(0);
                hold_req++;
                for (int i = 0; i < 40; i++)
                    pending_bytes.push_back(beat_of(8'($urandom), 1'b1));
                wait_idle();
            end
            set_idling(p % 4);
            // overlong datagram: bytes past the buffer are dropped
            if (p == 1)
                queue_datagram(DG_GOOD, MAX_DG - HDR_BYTES + 10, n);
            queue_random_traffic(PHASE_BYTES);
            wait_idle();
        end

        $display("run covered %0d byte beats and %0d verdict beats over %0d magic settings",
                 bytes_taken, verdicts_checked, magic_settings);
        $display("verdicts: ok %0d, bad magic %0d, length %0d, crc %0d, too short %0d",
                 verdict_tally[VRD_PASS], verdict_tally[VRD_MAGIC_ERR],
                 verdict_tally[VRD_LEN_ERR], verdict_tally[VRD_CRC_ERR],
                 verdict_tally[VRD_RUNT]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
